[rtl/spa_pkg.sv]
`default_nettype none

package spa_pkg;

    // Table capacity per polynomial and result limit per finish
    localparam int MAX_TERMS   = 8;
    localparam int MAX_RESULTS = 16;

    localparam int COEF_W = 16;
    localparam int SUM_W  = 17;
    localparam int EXP_W  = 8;
    localparam int FUNC_W = 2;

    // Widths that follow from the capacity
    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int IDX_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int STEP_W = $clog2(2 * MAX_TERMS);
    localparam int RES_W  = $clog2(MAX_RESULTS + 1);

    // Command codes on func
    localparam logic [FUNC_W-1:0] FUNC_LOAD_FIRST  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_SECOND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FINISH      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_EMIT_MATCH,
        ST_EMIT_FIRST,
        ST_EMIT_SECOND,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PROBE,
        CELL_ROT_FIRST,
        CELL_ROT_SECOND,
        CELL_CLEAR
    } cell_op_t;

    // Entry of the first polynomial, with its match result
    typedef struct packed {
        logic                     valid;
        logic                     match;
        logic signed [COEF_W-1:0] coef;
        logic        [EXP_W-1:0]  exp;
        logic signed [SUM_W-1:0]  sum;
    } first_ent_t;

    // Entry of the second polynomial; also the probe that travels the chain
    typedef struct packed {
        logic                     valid;
        logic                     hit;
        logic signed [COEF_W-1:0] coef;
        logic        [EXP_W-1:0]  exp;
    } sec_ent_t;

    // Controls broadcast from the sequencer to every cell
    typedef struct packed {
        cell_op_t                 op;
        logic                     load_first;
        logic                     load_second;
        logic        [IDX_W-1:0]  load_idx;
        logic signed [COEF_W-1:0] load_coef;
        logic        [EXP_W-1:0]  load_exp;
    } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/sparse_polynomial_adder_top.sv]
`default_nettype none

// Sparse polynomial adder. A transaction is taken when start is high and busy is
// low. Loads (func 0 first polynomial, func 1 second) give no result and leave busy
// low; a load into a full table of MAX_TERMS entries is dropped and flagged on
// dropped_terms. A finish (func 2) holds busy through a probe phase, in which every
// second-polynomial term travels once through the row of cells and is compared
// against each first-polynomial term, then three passes that rotate the tables past
// the head cell, first matched sums, then unmatched first terms, then unmatched
// second terms, and a closing state that clears the tables. Results come out on
// result_valid for one cycle each, possibly with gaps, at most MAX_RESULTS per
// finish; the final one carries last_term and appears in the cycle after the closing
// state, when busy is already low. The receiver cannot stall: every strobed result
// must be taken on that cycle. Func code 3 is ignored.

module sparse_polynomial_adder_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic        [spa_pkg::FUNC_W-1:0] func,
    input  wire logic signed [spa_pkg::COEF_W-1:0] coefficient,
    input  wire logic        [spa_pkg::EXP_W-1:0]  exponent,
    output logic                                   result_valid,
    output logic signed      [spa_pkg::SUM_W-1:0]  sum_coefficient,
    output logic             [spa_pkg::EXP_W-1:0]  sum_exponent,
    output logic                                   last_term,
    output logic                                   empty_sum,
    output logic                                   dropped_terms
);
    import spa_pkg::*;

    cell_ctl_t  ctl;
    first_ent_t first_q   [MAX_TERMS];
    sec_ent_t   second_q  [MAX_TERMS];
    sec_ent_t   probe_q   [MAX_TERMS];
    first_ent_t first_in  [MAX_TERMS];
    sec_ent_t   second_in [MAX_TERMS];
    sec_ent_t   probe_in  [MAX_TERMS];
    logic       wr_first  [MAX_TERMS];
    logic       wr_second [MAX_TERMS];

    spa_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .func            (func),
        .coefficient     (coefficient),
        .exponent        (exponent),
        .first_head      (first_q[0]),
        .second_head     (second_q[0]),
        .ctl             (ctl),
        .result_valid    (result_valid),
        .sum_coefficient (sum_coefficient),
        .sum_exponent    (sum_exponent),
        .last_term       (last_term),
        .empty_sum       (empty_sum),
        .dropped_terms   (dropped_terms)
    );

    for (genvar i = 0; i < MAX_TERMS; i++)
    begin : g_cell
        localparam int NXT = (i + 1) % MAX_TERMS;

        // Decode the table slot written by a load
        assign wr_first[i]  = ctl.load_first  && (ctl.load_idx == IDX_W'(i));
        assign wr_second[i] = ctl.load_second && (ctl.load_idx == IDX_W'(i));

        // First table rotates toward the head
        assign first_in[i] = first_q[NXT];

        // Second table shifts toward the head; its tail closes the probe ring
        if (i == MAX_TERMS - 1)
        begin : g_tail
            assign second_in[i] = (ctl.op == CELL_PROBE) ? probe_q[i] : second_q[0];
        end
        else
        begin : g_body
            assign second_in[i] = second_q[i + 1];
        end

        // Probes enter at the head from the second table and move down the row
        if (i == 0)
        begin : g_head
            assign probe_in[i] = second_q[0];
        end
        else
        begin : g_rest
            assign probe_in[i] = probe_q[i - 1];
        end

        spa_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .wr_first   (wr_first[i]),
            .wr_second  (wr_second[i]),
            .first_in   (first_in[i]),
            .second_in  (second_in[i]),
            .probe_in   (probe_in[i]),
            .first_out  (first_q[i]),
            .second_out (second_q[i]),
            .probe_out  (probe_q[i])
        );
    end

endmodule

`default_nettype wire

[rtl/spa_cell.sv]
`default_nettype none

module spa_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire spa_pkg::cell_ctl_t  ctl,
    input  wire logic                wr_first,
    input  wire logic                wr_second,
    input  wire spa_pkg::first_ent_t first_in,
    input  wire spa_pkg::sec_ent_t   second_in,
    input  wire spa_pkg::sec_ent_t   probe_in,
    output spa_pkg::first_ent_t      first_out,
    output spa_pkg::sec_ent_t        second_out,
    output spa_pkg::sec_ent_t        probe_out
);
    import spa_pkg::*;

    first_ent_t first_reg, first_next;
    sec_ent_t   second_reg, second_next;
    sec_ent_t   probe_reg, probe_next;
    logic       exp_eq;

    // Compare the passing probe against the local first-polynomial term
    assign exp_eq = probe_reg.valid && first_reg.valid && (probe_reg.exp == first_reg.exp);

    always_comb
    begin
        probe_out     = probe_reg;
        probe_out.hit = probe_reg.hit | exp_eq;
    end

    assign first_out  = first_reg;
    assign second_out = second_reg;

    // Update the cell contents for the broadcast operation
    always_comb
    begin
        first_next  = first_reg;
        second_next = second_reg;
        probe_next  = probe_reg;
        unique case (ctl.op)
            CELL_HOLD:
            begin
                if (wr_first)
                begin
                    first_next.valid = 1'b1;
                    first_next.match = 1'b0;
                    first_next.coef  = ctl.load_coef;
                    first_next.exp   = ctl.load_exp;
                    first_next.sum   = '0;
                end
                if (wr_second)
                begin
                    second_next.valid = 1'b1;
                    second_next.hit   = 1'b0;
                    second_next.coef  = ctl.load_coef;
                    second_next.exp   = ctl.load_exp;
                end
            end
            CELL_PROBE:
            begin
                // advance the probe ring and latch the first match only
                probe_next  = probe_in;
                second_next = second_in;
                if (exp_eq && !first_reg.match)
                begin
                    first_next.match = 1'b1;
                    first_next.sum   = {first_reg.coef[COEF_W-1], first_reg.coef}
                                     + {probe_reg.coef[COEF_W-1], probe_reg.coef};
                end
            end
            CELL_ROT_FIRST:
            begin
                first_next = first_in;
            end
            CELL_ROT_SECOND:
            begin
                second_next = second_in;
            end
            CELL_CLEAR:
            begin
                first_next.valid  = 1'b0;
                first_next.match  = 1'b0;
                second_next.valid = 1'b0;
                second_next.hit   = 1'b0;
                probe_next.valid  = 1'b0;
                probe_next.hit    = 1'b0;
            end
            default:
            begin
                first_next = first_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            second_reg <= '0;
            probe_reg  <= '0;
        end
        else
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            probe_reg  <= probe_next;
        end
    end

endmodule

`default_nettype wire

[rtl/spa_ctrl.sv]
`default_nettype none

module spa_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic        [spa_pkg::FUNC_W-1:0] func,
    input  wire logic signed [spa_pkg::COEF_W-1:0] coefficient,
    input  wire logic        [spa_pkg::EXP_W-1:0]  exponent,
    input  wire spa_pkg::first_ent_t            first_head,
    input  wire spa_pkg::sec_ent_t              second_head,
    output spa_pkg::cell_ctl_t                  ctl,
    output logic                                result_valid,
    output logic signed [spa_pkg::SUM_W-1:0]    sum_coefficient,
    output logic        [spa_pkg::EXP_W-1:0]    sum_exponent,
    output logic                                last_term,
    output logic                                empty_sum,
    output logic                                dropped_terms
);
    import spa_pkg::*;

    localparam logic [STEP_W-1:0] LAST_PROBE = STEP_W'(2 * MAX_TERMS - 1);
    localparam logic [STEP_W-1:0] LAST_EMIT  = STEP_W'(MAX_TERMS - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT   = CNT_W'(MAX_TERMS);
    localparam logic [RES_W-1:0]  RES_LIMIT  = RES_W'(MAX_RESULTS);

    ctrl_state_t              state_reg, state_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [CNT_W-1:0]         first_cnt_reg, first_cnt_next;
    logic [CNT_W-1:0]         second_cnt_reg, second_cnt_next;
    logic                     overflow_reg, overflow_next;
    logic [RES_W-1:0]         res_cnt_reg, res_cnt_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic signed [SUM_W-1:0]  pend_coef_reg, pend_coef_next;
    logic [EXP_W-1:0]         pend_exp_reg, pend_exp_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [SUM_W-1:0]  out_coef_reg, out_coef_next;
    logic [EXP_W-1:0]         out_exp_reg, out_exp_next;
    logic                     out_last_reg, out_last_next;
    logic                     out_empty_reg, out_empty_next;
    logic                     out_drop_reg, out_drop_next;

    logic                     cand;
    logic signed [SUM_W-1:0]  cand_coef;
    logic [EXP_W-1:0]         cand_exp;
    logic                     step_wrap;

    assign busy = (state_reg != ST_IDLE);

    assign step_wrap = (state_reg == ST_PROBE) ? (step_reg == LAST_PROBE)
                                               : (step_reg == LAST_EMIT);

    // Next state of the finish sequence
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && func == FUNC_FINISH)
                    state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                if (step_wrap)
                    state_next = ST_EMIT_MATCH;
            end
            ST_EMIT_MATCH:
            begin
                if (step_wrap)
                    state_next = ST_EMIT_FIRST;
            end
            ST_EMIT_FIRST:
            begin
                if (step_wrap)
                    state_next = ST_EMIT_SECOND;
            end
            ST_EMIT_SECOND:
            begin
                if (step_wrap)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Pick the candidate result from the head cell of the chain
    always_comb
    begin
        cand      = 1'b0;
        cand_coef = first_head.sum;
        cand_exp  = first_head.exp;
        unique case (state_reg)
            ST_EMIT_MATCH:
            begin
                cand = first_head.valid && first_head.match;
            end
            ST_EMIT_FIRST:
            begin
                cand      = first_head.valid && !first_head.match;
                cand_coef = {first_head.coef[COEF_W-1], first_head.coef};
            end
            ST_EMIT_SECOND:
            begin
                cand      = second_head.valid && !second_head.hit;
                cand_coef = {second_head.coef[COEF_W-1], second_head.coef};
                cand_exp  = second_head.exp;
            end
            ST_IDLE, ST_PROBE, ST_DONE:
            begin
                cand = 1'b0;
            end
            default:
            begin
                cand = 1'b0;
            end
        endcase
    end

    // Outputs: cell controls, table counts, pending and emitted results
    always_comb
    begin
        ctl.op          = CELL_HOLD;
        ctl.load_first  = 1'b0;
        ctl.load_second = 1'b0;
        ctl.load_idx    = '0;
        ctl.load_coef   = coefficient;
        ctl.load_exp    = exponent;

        step_next       = '0;
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        overflow_next   = overflow_reg;
        res_cnt_next    = res_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_coef_next  = pend_coef_reg;
        pend_exp_next   = pend_exp_reg;

        out_valid_next  = 1'b0;
        out_coef_next   = pend_coef_reg;
        out_exp_next    = pend_exp_reg;
        out_last_next   = 1'b0;
        out_empty_next  = 1'b0;
        out_drop_next   = overflow_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && func == FUNC_LOAD_FIRST)
                begin
                    if (first_cnt_reg < FULL_CNT)
                    begin
                        ctl.load_first = 1'b1;
                        ctl.load_idx   = first_cnt_reg[IDX_W-1:0];
                        first_cnt_next = first_cnt_reg + 1'b1;
                    end
                    else
                        overflow_next = 1'b1;
                end
                else if (start && func == FUNC_LOAD_SECOND)
                begin
                    if (second_cnt_reg < FULL_CNT)
                    begin
                        ctl.load_second = 1'b1;
                        ctl.load_idx    = second_cnt_reg[IDX_W-1:0];
                        second_cnt_next = second_cnt_reg + 1'b1;
                    end
                    else
                        overflow_next = 1'b1;
                end
            end
            ST_PROBE:
            begin
                ctl.op    = CELL_PROBE;
                step_next = step_wrap ? '0 : step_reg + 1'b1;
            end
            ST_EMIT_MATCH, ST_EMIT_FIRST, ST_EMIT_SECOND:
            begin
                ctl.op    = (state_reg == ST_EMIT_SECOND) ? CELL_ROT_SECOND : CELL_ROT_FIRST;
                step_next = step_wrap ? '0 : step_reg + 1'b1;
                // hold one result back so the final one can carry last_term
                if (cand && res_cnt_reg < RES_LIMIT)
                begin
                    out_valid_next  = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_coef_next  = cand_coef;
                    pend_exp_next   = cand_exp;
                    res_cnt_next    = res_cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                ctl.op          = CELL_CLEAR;
                out_valid_next  = 1'b1;
                out_last_next   = 1'b1;
                if (!pend_valid_reg)
                begin
                    out_coef_next  = '0;
                    out_exp_next   = '0;
                    out_empty_next = 1'b1;
                end
                first_cnt_next  = '0;
                second_cnt_next = '0;
                overflow_next   = 1'b0;
                res_cnt_next    = '0;
                pend_valid_next = 1'b0;
            end
            default:
            begin
                ctl.op = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            overflow_reg   <= 1'b0;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            overflow_reg   <= overflow_next;
            res_cnt_reg    <= res_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge clk)
    begin
        pend_coef_reg <= pend_coef_next;
        pend_exp_reg  <= pend_exp_next;
        out_coef_reg  <= out_coef_next;
        out_exp_reg   <= out_exp_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_drop_reg  <= out_drop_next;
    end

    assign result_valid    = out_valid_reg;
    assign sum_coefficient = out_coef_reg;
    assign sum_exponent    = out_exp_reg;
    assign last_term       = out_last_reg;
    assign empty_sum       = out_empty_reg;
    assign dropped_terms   = out_drop_reg;

endmodule

`default_nettype wire

[tb/tb_top.sv]
module tb_top;
    import spa_pkg::*;

    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 350;
    localparam int QUIET_ITEMS   = 60;
    localparam int FINISH_CYCLES = 5 * MAX_TERMS + 1;
    localparam int TAIL_CYCLES   = FINISH_CYCLES + 10;
    localparam int CYCLE_LIMIT   = 200000;

    // Code that the block ignores
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        logic signed [SUM_W-1:0] coef;
        logic        [EXP_W-1:0] expo;
        logic                    last;
        logic                    empty;
        logic                    dropped;
    } sum_term_t;

    // Term tables of both polynomials and the sum terms still to come
    class sum_scoreboard;
        logic signed [COEF_W-1:0] first_coef   [MAX_TERMS];
        logic        [EXP_W-1:0]  first_expo   [MAX_TERMS];
        logic signed [COEF_W-1:0] second_coef  [MAX_TERMS];
        logic        [EXP_W-1:0]  second_expo  [MAX_TERMS];
        int                       first_cnt;
        int                       second_cnt;
        bit                       overflow;
        sum_term_t                finish_terms[$];
        sum_term_t                expected_terms[$];
        int                       error_count;

        function new();
            first_cnt   = 0;
            second_cnt  = 0;
            overflow    = 1'b0;
            error_count = 0;
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            error_count++;
        endtask

        // Append one sum term, capped at the per-finish result limit
        function void emit_term(int c, logic [EXP_W-1:0] e);
            sum_term_t t;
            if (finish_terms.size() >= MAX_RESULTS)
                return;
            t.coef    = c[SUM_W-1:0];
            t.expo    = e;
            t.last    = 1'b0;
            t.empty   = 1'b0;
            t.dropped = overflow;
            finish_terms.push_back(t);
        endfunction

        // Build the sum terms of a finish, then clear both tables
        function void add_polys();
            bit        hit;
            sum_term_t t;
            finish_terms.delete();
            if (first_cnt == 0 && second_cnt == 0)
            begin
                emit_term(0, '0);
                t = finish_terms.pop_back();
                t.empty = 1'b1;
                finish_terms.push_back(t);
            end
            else
            begin
                // matched first terms, summed with the first matching second term
                for (int i = 0; i < first_cnt; i++)
                begin
                    hit = 1'b0;
                    for (int j = 0; j < second_cnt && !hit; j++)
                    begin
                        if (first_expo[i] == second_expo[j])
                        begin
                            emit_term(int'(first_coef[i]) + int'(second_coef[j]),
                                      first_expo[i]);
                            hit = 1'b1;
                        end
                    end
                end
                // unmatched first terms
                for (int i = 0; i < first_cnt; i++)
                begin
                    hit = 1'b0;
                    for (int j = 0; j < second_cnt; j++)
                        if (first_expo[i] == second_expo[j])
                            hit = 1'b1;
                    if (!hit)
                        emit_term(int'(first_coef[i]), first_expo[i]);
                end
                // unmatched second terms
                for (int j = 0; j < second_cnt; j++)
                begin
                    hit = 1'b0;
                    for (int i = 0; i < first_cnt; i++)
                        if (first_expo[i] == second_expo[j])
                            hit = 1'b1;
                    if (!hit)
                        emit_term(int'(second_coef[j]), second_expo[j]);
                end
            end
            // mark the final term of this finish
            t = finish_terms.pop_back();
            t.last = 1'b1;
            finish_terms.push_back(t);
            foreach (finish_terms[k])
                expected_terms.push_back(finish_terms[k]);
            first_cnt  = 0;
            second_cnt = 0;
            overflow   = 1'b0;
        endfunction

        // Update the tables for one accepted transaction
        function void note_command(logic [FUNC_W-1:0] f, logic signed [COEF_W-1:0] c,
                                   logic [EXP_W-1:0] e);
            case (f)
                FUNC_LOAD_FIRST:
                begin
                    if (first_cnt < MAX_TERMS)
                    begin
                        first_coef[first_cnt] = c;
                        first_expo[first_cnt] = e;
                        first_cnt++;
                    end
                    else
                        overflow = 1'b1;
                end
                FUNC_LOAD_SECOND:
                begin
                    if (second_cnt < MAX_TERMS)
                    begin
                        second_coef[second_cnt] = c;
                        second_expo[second_cnt] = e;
                        second_cnt++;
                    end
                    else
                        overflow = 1'b1;
                end
                FUNC_FINISH:
                    add_polys();
                default:
                    ;
            endcase
        endfunction

        // Compare one strobed term with the oldest expected term
        task check_term(sum_term_t got);
            sum_term_t want;
            if (expected_terms.size() == 0)
            begin
                report($sformatf("unexpected term coef %0d exp %0d", got.coef, got.expo));
                return;
            end
            want = expected_terms.pop_front();
            if (got.coef !== want.coef)
                report($sformatf("sum_coefficient %0d, want %0d", got.coef, want.coef));
            if (got.expo !== want.expo)
                report($sformatf("sum_exponent %0d, want %0d", got.expo, want.expo));
            if (got.last !== want.last)
                report($sformatf("last_term %b, want %b", got.last, want.last));
            if (got.empty !== want.empty)
                report($sformatf("empty_sum %b, want %b", got.empty, want.empty));
            if (got.dropped !== want.dropped)
                report($sformatf("dropped_terms %b, want %b", got.dropped, want.dropped));
        endtask
    endclass

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     start       = 1'b0;
    logic        [FUNC_W-1:0] func        = '0;
    logic signed [COEF_W-1:0] coefficient = '0;
    logic        [EXP_W-1:0]  exponent    = '0;
    logic                     busy;
    logic                     result_valid;
    logic signed [SUM_W-1:0]  sum_coefficient;
    logic        [EXP_W-1:0]  sum_exponent;
    logic                     last_term;
    logic                     empty_sum;
    logic                     dropped_terms;

    sum_scoreboard sb;
    sum_term_t     seen_term;
    int            item_count;
    int            cycle_count;
    bit            idle_on;

    sparse_polynomial_adder_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .func            (func),
        .coefficient     (coefficient),
        .exponent        (exponent),
        .result_valid    (result_valid),
        .sum_coefficient (sum_coefficient),
        .sum_exponent    (sum_exponent),
        .last_term       (last_term),
        .empty_sum       (empty_sum),
        .dropped_terms   (dropped_terms)
    );

    // Generate the clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Capture every strobed term
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
        begin
            seen_term.coef    = sum_coefficient;
            seen_term.expo    = sum_exponent;
            seen_term.last    = last_term;
            seen_term.empty   = empty_sum;
            seen_term.dropped = dropped_terms;
            sb.check_term(seen_term);
        end
    end

    // Drive one transaction and hold it until accepted
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic signed [COEF_W-1:0] c,
                             input logic [EXP_W-1:0] e);
        start       <= 1'b1;
        func        <= f;
        coefficient <= c;
        exponent    <= e;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_command(f, c, e);
        if (f != FUNC_UNUSED)
            item_count++;
    endtask

    // Insert an idle burst now and then, none in the closing stretch
    task automatic maybe_idle();
        if (idle_on && item_count < RANDOM_ITEMS - QUIET_ITEMS && $urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // Hold off until every expected term has arrived
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_terms.size() != 0);
    endtask

    function automatic logic signed [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 19))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3:       return '1;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // Narrow ranges make matches likely; the full range covers every bit
    function automatic logic [EXP_W-1:0] rand_expo(int mode);
        case (mode)
            0:       return EXP_W'($urandom_range(0, 7));
            1:       return EXP_W'($urandom_range(248, 255));
            default: return EXP_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 0;
        else if (r < 85)
            return $urandom_range(1, MAX_TERMS);
        else
            return $urandom_range(MAX_TERMS + 1, MAX_TERMS + 3);
    endfunction

    // Load two random polynomials in mixed order, with some noise, then finish
    task automatic run_pair();
        int n1;
        int n2;
        int mode;
        n1      = pick_count();
        n2      = pick_count();
        mode    = $urandom_range(0, 2);
        idle_on = ($urandom_range(0, 9) < 7);
        while (n1 + n2 > 0)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(FUNC_UNUSED, rand_coef(), rand_expo(2));
            else if (n2 == 0 || (n1 > 0 && $urandom_range(0, 1) == 1))
            begin
                send_item(FUNC_LOAD_FIRST, rand_coef(), rand_expo(mode));
                n1--;
            end
            else
            begin
                send_item(FUNC_LOAD_SECOND, rand_coef(), rand_expo(mode));
                n2--;
            end
            maybe_idle();
        end
        send_item(FUNC_FINISH, COEF_W'($urandom), EXP_W'($urandom));
        maybe_idle();
        if ($urandom_range(0, 9) == 0)
            wait_drained();
    endtask

    // Bound the run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        sb         = new();
        item_count = 0;
        idle_on    = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty sum, with the finish fields set to nonzero values
        send_item(FUNC_FINISH, 16'sh1234, 8'hA5);
        // unused code leaves the tables alone
        send_item(FUNC_UNUSED, '1, 8'hFF);
        send_item(FUNC_FINISH, '0, '0);

        // extremes that match, duplicate exponents on both sides, unmatched terms
        send_item(FUNC_LOAD_FIRST, 16'sh7FFF, 8'd255);
        send_item(FUNC_LOAD_FIRST, 16'sh8000, 8'd0);
        send_item(FUNC_LOAD_FIRST, 16'sd7, 8'd0);
        send_item(FUNC_LOAD_SECOND, 16'sh7FFF, 8'd255);
        send_item(FUNC_LOAD_SECOND, 16'sh8000, 8'd0);
        send_item(FUNC_LOAD_SECOND, 16'sd5, 8'd0);
        send_item(FUNC_LOAD_SECOND, 16'sd1, 8'd17);
        send_item(FUNC_LOAD_FIRST, '1, 8'd128);
        send_item(FUNC_FINISH, '1, '1);

        // overfill the first table
        for (int k = 0; k <= MAX_TERMS; k++)
            send_item(FUNC_LOAD_FIRST, COEF_W'(k * 1000 - 4000), EXP_W'(k));
        send_item(FUNC_FINISH, '0, '0);
        wait_drained();

        // random polynomial pairs
        item_count = 0;
        while (item_count < RANDOM_ITEMS)
            run_pair();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.expected_terms.size() != 0)
            sb.report($sformatf("%0d terms never arrived", sb.expected_terms.size()));
        if (sb.error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
